>>> design/sss_pkg.sv
// Shared widths, constants and the set summary record for the sample set statistics block.
package sss_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_COUNT   = 65536;

    localparam int COUNT_W = 17;
    localparam int SUM_W   = 33;
    localparam int SUMSQ_W = 48;
    localparam int MAG_W   = 32;
    localparam int PROD_W  = 64;
    localparam int WIDE_W  = 63;
    localparam int NSQ_W   = 33;
    localparam int DIV_W   = 79;
    localparam int DCNT_W  = 7;
    localparam int V16_W   = 47;
    localparam int RAD_W   = 48;
    localparam int ROOT_W  = 24;
    localparam int SREM_W  = 26;
    localparam int SCNT_W  = 5;
    localparam int MEAN_W  = 24;
    localparam int VAR_W   = 39;
    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = 1;
    localparam int QCNT_W  = 2;

    localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(MAX_COUNT);
    localparam logic signed [SAMPLE_BITS-1:0] MOST_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef struct packed {
        logic [COUNT_W-1:0]            count;
        logic signed [SAMPLE_BITS-1:0] min_val;
        logic signed [SAMPLE_BITS-1:0] max_val;
        logic signed [SUM_W-1:0]       sum;
        logic [SUMSQ_W-1:0]            sumsq;
        logic                          ovf;
    } set_summary_t;

endpackage

>>> design/sss_front.sv
// Front end: accumulates count, min, max, sum and sum of squares, one sample a cycle unless the queue is full.
module sss_front
    import sss_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          last,
    input  logic                          in_valid,
    output logic                          in_stall,
    output logic                          push,
    output set_summary_t                  push_data,
    input  logic                          q_full
);

    logic [COUNT_W-1:0]            count_reg, count_next;
    logic signed [SAMPLE_BITS-1:0] min_reg, min_next;
    logic signed [SAMPLE_BITS-1:0] max_reg, max_next;
    logic signed [SUM_W-1:0]       sum_reg, sum_next;
    logic [SUMSQ_W-1:0]            sumsq_reg, sumsq_next;
    logic                          ovf_reg, ovf_next;
    logic                          take;
    logic                          room;
    logic signed [2*SAMPLE_BITS-1:0] sq;

    assign in_stall = q_full;
    assign take     = in_valid && !q_full;
    assign room     = count_reg < COUNT_LIMIT;
    assign sq       = sample * sample;

    always_comb
    begin
        count_next = count_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        sum_next   = sum_reg;
        sumsq_next = sumsq_reg;
        ovf_next   = ovf_reg;
        if (room)
        begin
            count_next = count_reg + COUNT_W'(1);
            if (sample < min_reg)
            begin
                min_next = sample;
            end
            if (sample > max_reg)
            begin
                max_next = sample;
            end
            sum_next   = sum_reg + SUM_W'(sample);
            sumsq_next = sumsq_reg + SUMSQ_W'($unsigned(sq));
        end
        else
        begin
            ovf_next = 1'b1;
        end
    end

    assign push              = take && last;
    assign push_data.count   = count_next;
    assign push_data.min_val = min_next;
    assign push_data.max_val = max_next;
    assign push_data.sum     = sum_next;
    assign push_data.sumsq   = sumsq_next;
    assign push_data.ovf     = ovf_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            min_reg   <= MOST_POS;
            max_reg   <= MOST_NEG;
            sum_reg   <= '0;
            sumsq_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (take)
        begin
            if (last)
            begin
                // close the set: summary goes to the queue, start fresh
                count_reg <= '0;
                min_reg   <= MOST_POS;
                max_reg   <= MOST_NEG;
                sum_reg   <= '0;
                sumsq_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                count_reg <= count_next;
                min_reg   <= min_next;
                max_reg   <= max_next;
                sum_reg   <= sum_next;
                sumsq_reg <= sumsq_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

endmodule

>>> design/sss_queue.sv
// Short queue of set summaries between the front end and the back end.
module sss_queue
    import sss_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  set_summary_t push_data,
    output logic         full,
    input  logic         pop,
    output logic         q_valid,
    output set_summary_t q_data
);

    set_summary_t       mem [Q_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic               do_pop;

    assign full    = count_reg == QCNT_W'(Q_DEPTH);
    assign q_valid = count_reg != '0;
    assign q_data  = mem[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (do_pop && !push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("summary pushed into a full queue");

endmodule

>>> design/sss_divider.sv
// Restoring divider, one quotient bit per cycle, shared by the mean and variance steps.
module sss_divider
    import sss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [NSQ_W-1:0]  divisor,
    output logic              done,
    output logic [DIV_W-1:0]  quotient
);

    logic [DIV_W-1:0]  dvd_reg;
    logic [NSQ_W-1:0]  dsr_reg;
    logic [NSQ_W-1:0]  rem_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [NSQ_W:0]    rem_sh;
    logic              ge;
    logic [NSQ_W:0]    rem_sub;

    assign rem_sh  = {rem_reg, dvd_reg[DIV_W-1]};
    assign ge      = rem_sh >= {1'b0, dsr_reg};
    assign rem_sub = rem_sh - {1'b0, dsr_reg};

    assign done     = done_reg;
    assign quotient = dvd_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            // shift the quotient bit in where the dividend bit left
            dvd_reg <= {dvd_reg[DIV_W-2:0], ge};
            rem_reg <= ge ? rem_sub[NSQ_W-1:0] : rem_sh[NSQ_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == DCNT_W'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + DCNT_W'(1);
            end
        end
    end

endmodule

>>> design/sss_back.sv
// Back end: products, mean, variance and square root of one set, then the result register.
module sss_back
    import sss_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  set_summary_t                  q_data,
    output logic                          pop,
    output logic [COUNT_W-1:0]            sample_count,
    output logic signed [SAMPLE_BITS-1:0] smallest,
    output logic signed [SAMPLE_BITS-1:0] largest,
    output logic [SAMPLE_BITS-1:0]        spread,
    output logic signed [MEAN_W-1:0]      average,
    output logic [VAR_W-1:0]              variance_q8,
    output logic [ROOT_W-1:0]             deviation_q8,
    output logic                          overflowed,
    output logic                          out_valid,
    input  logic                          out_stall
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_M0   = 4'd1;
    localparam logic [3:0] S_M1   = 4'd2;
    localparam logic [3:0] S_M2   = 4'd3;
    localparam logic [3:0] S_M3   = 4'd4;
    localparam logic [3:0] S_M4   = 4'd5;
    localparam logic [3:0] S_MS   = 4'd6;
    localparam logic [3:0] S_MW   = 4'd7;
    localparam logic [3:0] S_VS   = 4'd8;
    localparam logic [3:0] S_VW   = 4'd9;
    localparam logic [3:0] S_RS   = 4'd10;
    localparam logic [3:0] S_RW   = 4'd11;
    localparam logic [3:0] S_OUT  = 4'd12;

    logic [3:0]          state_reg, state_next;
    set_summary_t        ent_reg;
    logic [MAG_W-1:0]    smag_reg;
    logic                neg_reg;
    logic [PROD_W-1:0]   p_reg;
    logic [WIDE_W-1:0]   a_reg;
    logic [WIDE_W-1:0]   b_reg;
    logic [WIDE_W-1:0]   d_reg;
    logic [NSQ_W-1:0]    nsq_reg;
    logic [MEAN_W-1:0]   mean_reg;
    logic [V16_W-1:0]    v16_reg;
    logic [RAD_W-1:0]    rad_reg;
    logic [SREM_W-1:0]   srem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [SCNT_W-1:0]   scnt_reg;
    logic                out_valid_reg;

    logic [MAG_W-1:0]    mul_a, mul_b;
    logic [PROD_W-1:0]   prod;
    logic [SUM_W-1:0]    sum_abs;
    logic                div_start;
    logic                div_done;
    logic [DIV_W-1:0]    div_dividend;
    logic [NSQ_W-1:0]    div_divisor;
    logic [DIV_W-1:0]    div_quot;
    logic [SREM_W+1:0]   srem_sh;
    logic [SREM_W+1:0]   strial;
    logic                sge;
    logic                out_load;

    assign pop      = (state_reg == S_IDLE) && q_valid;
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);
    assign sum_abs  = q_data.sum[SUM_W-1] ? SUM_W'(-q_data.sum) : q_data.sum;

    // one shared multiplier; operands follow the sequencer
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_M0:
            begin
                mul_a = MAG_W'(ent_reg.count);
                mul_b = MAG_W'(ent_reg.sumsq[23:0]);
            end
            S_M1:
            begin
                mul_a = MAG_W'(ent_reg.count);
                mul_b = MAG_W'(ent_reg.sumsq[SUMSQ_W-1:24]);
            end
            S_M2:
            begin
                mul_a = smag_reg;
                mul_b = smag_reg;
            end
            S_M3:
            begin
                mul_a = MAG_W'(ent_reg.count);
                mul_b = MAG_W'(ent_reg.count);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign div_start    = (state_reg == S_MS) || (state_reg == S_VS);
    assign div_dividend = (state_reg == S_VS) ? {d_reg, 16'b0} : DIV_W'({smag_reg, 8'b0});
    assign div_divisor  = (state_reg == S_VS) ? nsq_reg : NSQ_W'(ent_reg.count);

    sss_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // square root: two radicand bits per step
    assign srem_sh = {srem_reg, rad_reg[RAD_W-1:RAD_W-2]};
    assign strial  = (SREM_W+2)'({root_reg, 2'b01});
    assign sge     = srem_sh >= strial;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (q_valid) state_next = S_M0;
            S_M0:   state_next = S_M1;
            S_M1:   state_next = S_M2;
            S_M2:   state_next = S_M3;
            S_M3:   state_next = S_M4;
            S_M4:   state_next = S_MS;
            S_MS:   state_next = S_MW;
            S_MW:   if (div_done) state_next = S_VS;
            S_VS:   state_next = S_VW;
            S_VW:   if (div_done) state_next = S_RS;
            S_RS:   state_next = S_RW;
            S_RW:   if (scnt_reg == SCNT_W'(ROOT_W - 1)) state_next = S_OUT;
            S_OUT:  if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ent_reg  <= q_data;
            smag_reg <= sum_abs[MAG_W-1:0];
            neg_reg  <= q_data.sum[SUM_W-1];
        end
        p_reg <= prod;
        case (state_reg)
            S_M1: a_reg <= WIDE_W'(p_reg[40:0]);
            S_M2: a_reg <= a_reg + WIDE_W'({p_reg[40:0], 24'b0});
            S_M3: b_reg <= p_reg[WIDE_W-1:0];
            S_M4:
            begin
                nsq_reg <= p_reg[NSQ_W-1:0];
                // clamp at zero
                d_reg   <= (a_reg > b_reg) ? a_reg - b_reg : '0;
            end
            S_MW:
            begin
                if (div_done)
                begin
                    mean_reg <= neg_reg ? -div_quot[MEAN_W-1:0] : div_quot[MEAN_W-1:0];
                end
            end
            S_VW:
            begin
                if (div_done)
                begin
                    v16_reg <= div_quot[V16_W-1:0];
                end
            end
            S_RS:
            begin
                rad_reg  <= RAD_W'(v16_reg);
                srem_reg <= '0;
                root_reg <= '0;
                scnt_reg <= '0;
            end
            S_RW:
            begin
                rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
                srem_reg <= sge ? SREM_W'(srem_sh - strial) : SREM_W'(srem_sh);
                root_reg <= {root_reg[ROOT_W-2:0], sge};
                scnt_reg <= scnt_reg + SCNT_W'(1);
            end
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            sample_count <= ent_reg.count;
            smallest     <= ent_reg.min_val;
            largest      <= ent_reg.max_val;
            spread       <= SAMPLE_BITS'(ent_reg.max_val - ent_reg.min_val);
            average      <= mean_reg;
            variance_q8  <= v16_reg[V16_W-1:8];
            deviation_q8 <= root_reg;
            overflowed   <= ent_reg.ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_MW || state_reg == S_VW))
        else $error("divider finished outside a wait step");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> ((RAD_W'(root_reg) * RAD_W'(root_reg)) <= RAD_W'(v16_reg)))
        else $error("square root too large");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && neg_reg) |-> (mean_reg[MEAN_W-1] || mean_reg == '0))
        else $error("mean sign disagrees with sum sign");

endmodule

>>> design/sample_set_statistics_core.sv
// Top level of the sample set statistics block: front end, summary queue, back end.
//
//  channel  dir  handshake            beat
//  in       in   in_valid / in_stall  sample, last
//  out      out  out_valid/out_stall  sample_count, smallest, largest, spread,
//                                     average, variance_q8, deviation_q8, overflowed
//
// The front end takes one sample beat per cycle; in_stall rises only while the
// two-entry summary queue is full.
// The back end works on one set at a time: its multiplier steps, a mean and a variance
// pass of its restoring divider, then the square root.
// Reset clears the accumulators, the queue and the sequencer; no clearing pass.
// out_stall holds the result register and, once the queue fills, the input.
module sample_set_statistics_core
    import sss_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          last,
    input  logic                          in_valid,
    output logic                          in_stall,
    output logic [COUNT_W-1:0]            sample_count,
    output logic signed [SAMPLE_BITS-1:0] smallest,
    output logic signed [SAMPLE_BITS-1:0] largest,
    output logic [SAMPLE_BITS-1:0]        spread,
    output logic signed [MEAN_W-1:0]      average,
    output logic [VAR_W-1:0]              variance_q8,
    output logic [ROOT_W-1:0]             deviation_q8,
    output logic                          overflowed,
    output logic                          out_valid,
    input  logic                          out_stall
);

    logic         push;
    set_summary_t push_data;
    logic         q_full;
    logic         pop;
    logic         q_valid;
    set_summary_t q_data;

    sss_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample),
        .last      (last),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    sss_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    sss_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .pop          (pop),
        .sample_count (sample_count),
        .smallest     (smallest),
        .largest      (largest),
        .spread       (spread),
        .average      (average),
        .variance_q8  (variance_q8),
        .deviation_q8 (deviation_q8),
        .overflowed   (overflowed),
        .out_valid    (out_valid),
        .out_stall    (out_stall)
    );

endmodule
